// ===== rtl/qsed_pkg.sv =====
// ----------------------------------------------------------------------------
// qsed_pkg
// Types and character constants shared by the quoted string escape decoder.
// ----------------------------------------------------------------------------
package qsed_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_open_quote;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
        logic       string_done;
    } out_item_t;

    // Up to two results per input byte, first one lands in first
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } res_pair_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_PLAIN  = 3'd1,
        MODE_ESCAPE = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCTAL  = 3'd4
    } mode_t;

    // Result queue depth; pointers wrap naturally, so keep it a power of two
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_X_LOWER   = 8'h78;
    localparam logic [7:0] CH_X_UPPER   = 8'h58;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_A_LOWER   = 8'h61;
    localparam logic [7:0] CH_F_LOWER   = 8'h66;
    localparam logic [7:0] CH_A_UPPER   = 8'h41;
    localparam logic [7:0] CH_F_UPPER   = 8'h46;

    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_TAB = 8'd9;

    localparam logic [1:0] OCT_LAST = 2'd3;

    // Bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = c - CH_ZERO;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= CH_A_LOWER && c <= CH_F_LOWER) begin
                d = c - CH_A_LOWER + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end else if (c >= CH_A_UPPER && c <= CH_F_UPPER) begin
                d = c - CH_A_UPPER + 8'd10;
                hex_digit = {1'b1, d[3:0]};
            end else begin
                hex_digit = 5'd0;
            end
        end
    endfunction

endpackage

// ===== rtl/qsed_core.sv =====
// ----------------------------------------------------------------------------
// qsed_core
// Decode state and the per-byte step: one byte in, up to two results out.
// ----------------------------------------------------------------------------
module qsed_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  qsed_pkg::in_item_t item,
    output qsed_pkg::res_pair_t res
);

    qsed_pkg::mode_t mode_reg, mode_next;
    logic [7:0]      term_reg, term_next;
    logic [7:0]      acc_reg,  acc_next;
    logic [1:0]      cnt_reg,  cnt_next;

    logic [7:0]          c;
    logic                is_oct;
    logic [4:0]          hex;
    logic [1:0]          cnt_sum;
    logic                do_plain;
    logic                flush_acc;
    logic                plain_has;
    qsed_pkg::out_item_t plain_res;
    qsed_pkg::out_item_t direct_res;
    logic                direct_has;

    assign c       = item.data_byte;
    assign is_oct  = (c >= qsed_pkg::CH_ZERO) && (c <= qsed_pkg::CH_SEVEN);
    assign hex     = qsed_pkg::hex_digit(c);
    assign cnt_sum = cnt_reg + 2'd1;

    always_comb
    begin
        mode_next  = mode_reg;
        term_next  = term_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        do_plain   = 1'b0;
        flush_acc  = 1'b0;
        direct_has = 1'b0;
        direct_res = '0;
        plain_has  = 1'b0;
        plain_res  = '0;
        res        = '0;

        if (step) begin
            if (item.stream_end) begin
                if (mode_reg != qsed_pkg::MODE_IDLE) begin
                    if (mode_reg == qsed_pkg::MODE_HEX || mode_reg == qsed_pkg::MODE_OCTAL)
                    begin
                        res.first  = '{has_byte: 1'b1, out_byte: acc_reg, string_done: 1'b0};
                        res.second = '{has_byte: 1'b0, out_byte: 8'd0, string_done: 1'b1};
                        res.count  = 2'd2;
                    end else begin
                        res.first = '{has_byte: 1'b0, out_byte: 8'd0, string_done: 1'b1};
                        res.count = 2'd1;
                    end
                    mode_next = qsed_pkg::MODE_IDLE;
                    cnt_next  = 2'd0;
                end
            end else if (item.is_open_quote) begin
                term_next = c;
                mode_next = qsed_pkg::MODE_PLAIN;
                acc_next  = 8'd0;
                cnt_next  = 2'd0;
            end else begin
                case (mode_reg)
                    qsed_pkg::MODE_PLAIN:
                    begin
                        do_plain = 1'b1;
                    end
                    qsed_pkg::MODE_ESCAPE:
                    begin
                        mode_next  = qsed_pkg::MODE_PLAIN;
                        direct_has = 1'b1;
                        direct_res = '{has_byte: 1'b1, out_byte: c, string_done: 1'b0};
                        case (c)
                            qsed_pkg::CH_B: direct_res.out_byte = qsed_pkg::CODE_BS;
                            qsed_pkg::CH_F: direct_res.out_byte = qsed_pkg::CODE_FF;
                            qsed_pkg::CH_N: direct_res.out_byte = qsed_pkg::CODE_LF;
                            qsed_pkg::CH_R: direct_res.out_byte = qsed_pkg::CODE_CR;
                            qsed_pkg::CH_T: direct_res.out_byte = qsed_pkg::CODE_TAB;
                            qsed_pkg::CH_X_LOWER, qsed_pkg::CH_X_UPPER:
                            begin
                                direct_has = 1'b0;
                                mode_next  = qsed_pkg::MODE_HEX;
                                acc_next   = 8'd0;
                            end
                            default:
                            begin
                                if (is_oct) begin
                                    direct_has = 1'b0;
                                    mode_next  = qsed_pkg::MODE_OCTAL;
                                    acc_next   = {5'd0, c[2:0]};
                                    cnt_next   = 2'd1;
                                end
                            end
                        endcase
                    end
                    qsed_pkg::MODE_HEX:
                    begin
                        if (hex[4]) begin
                            acc_next = {acc_reg[3:0], hex[3:0]};
                        end else begin
                            flush_acc = 1'b1;
                            do_plain  = 1'b1;
                        end
                    end
                    qsed_pkg::MODE_OCTAL:
                    begin
                        if (is_oct) begin
                            acc_next = {acc_reg[4:0], c[2:0]};
                            cnt_next = cnt_sum;
                            if (cnt_sum == qsed_pkg::OCT_LAST) begin
                                mode_next  = qsed_pkg::MODE_PLAIN;
                                cnt_next   = 2'd0;
                                direct_has = 1'b1;
                                direct_res = '{has_byte: 1'b1, out_byte: {acc_reg[4:0], c[2:0]},
                                               string_done: 1'b0};
                            end
                        end else begin
                            cnt_next  = 2'd0;
                            flush_acc = 1'b1;
                            do_plain  = 1'b1;
                        end
                    end
                    default:
                    begin
                        mode_next = qsed_pkg::MODE_IDLE;
                    end
                endcase

                // Ordinary string byte: terminator, backslash or character
                if (do_plain) begin
                    if (c == term_reg) begin
                        mode_next = qsed_pkg::MODE_IDLE;
                        plain_has = 1'b1;
                        plain_res = '{has_byte: 1'b0, out_byte: 8'd0, string_done: 1'b1};
                    end else if (c == qsed_pkg::CH_BACKSLASH) begin
                        mode_next = qsed_pkg::MODE_ESCAPE;
                    end else begin
                        mode_next = qsed_pkg::MODE_PLAIN;
                        plain_has = 1'b1;
                        plain_res = '{has_byte: 1'b1, out_byte: c, string_done: 1'b0};
                    end
                end

                if (direct_has) begin
                    res.first = direct_res;
                    res.count = 2'd1;
                end else if (flush_acc) begin
                    res.first = '{has_byte: 1'b1, out_byte: acc_reg, string_done: 1'b0};
                    if (plain_has) begin
                        res.second = plain_res;
                        res.count  = 2'd2;
                    end else begin
                        res.count = 2'd1;
                    end
                end else if (plain_has) begin
                    res.first = plain_res;
                    res.count = 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= qsed_pkg::MODE_IDLE;
            term_reg <= 8'd0;
            acc_reg  <= 8'd0;
            cnt_reg  <= 2'd0;
        end else begin
            mode_reg <= mode_next;
            term_reg <= term_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/quoted_string_escape_decoder_top.sv =====
// ----------------------------------------------------------------------------
// quoted_string_escape_decoder_top
// Decodes the bytes of a quoted string literal, escapes included.
//
//   channel | handshake             | payload
//   --------+-----------------------+---------------------------------------
//   in      | in_valid / in_ready   | in_item  (data_byte, flags)
//   out     | out_valid / out_ready | out_item (has_byte, out_byte, done)
//
// One byte is taken per cycle while the result queue has room. A byte that
// yields two results (a flushed hex or octal value followed by its trailing
// byte or close) leaves them at the output port one after the other.
// The path runs through the input register, then decode into a four-entry
// result queue. A byte leaves the input register only while the queue has
// room for two results; output stalls back up through that check.
// Reset empties both stages and returns the decoder to idle.
// ----------------------------------------------------------------------------
module quoted_string_escape_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qsed_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output qsed_pkg::out_item_t out_item
);

    localparam int PW = $clog2(qsed_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(qsed_pkg::QUEUE_DEPTH + 1);

    logic               hold_valid_reg;
    qsed_pkg::in_item_t hold_item_reg;
    logic               advance;
    qsed_pkg::res_pair_t res;

    qsed_pkg::out_item_t queue_mem [qsed_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic [PW-1:0] wr_ptr_plus1;

    // Move on only with room for a two-result byte
    assign advance  = hold_valid_reg && (count_reg <= CW'(qsed_pkg::QUEUE_DEPTH - 2));
    assign in_ready = !hold_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else if (in_ready) begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            hold_item_reg <= in_item;
        end
    end

    qsed_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (hold_item_reg),
        .res   (res)
    );

    assign out_valid    = (count_reg != '0);
    assign out_item     = queue_mem[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(res.count);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(res.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (res.count != 2'd0) begin
            queue_mem[wr_ptr_reg] <= res.first;
        end
        if (res.count == 2'd2) begin
            queue_mem[wr_ptr_plus1] <= res.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(qsed_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_no_result_without_step : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |-> (res.count == 2'd0))
        else $error("result produced without a decode step");

    a_pair_fits : assert property (@(posedge clk) disable iff (!rst_n)
        (res.count == 2'd2) |=> (count_reg >= CW'(1)))
        else $error("two-result push lost");

    a_stall_holds_byte : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> hold_valid_reg)
        else $error("input stalled with empty input register");
`endif

endmodule

// ===== tb/sv/tb_quoted_string_escape_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_quoted_string_escape_decoder_top
// Self-checking bench for the quoted string escape decoder. A short directed
// sequence covers named, hex, octal and other escapes, pending value
// flushes, stream end and re-opened strings. It is followed by random
// well-formed strings with some noise. A scoreboard class predicts each
// decoded character and close marker and checks every output transfer.
// Sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module tb_quoted_string_escape_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         ITEM_TARGET = 950;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_WAIT  = 20;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;

    class escape_scoreboard;
        qsed_pkg::mode_t     mode;
        logic [7:0]          term;
        logic [7:0]          acc;
        logic [1:0]          oct_cnt;
        qsed_pkg::out_item_t expected_chars[$];
        int                  errors;
        int                  live_items;

        function new();
            mode       = qsed_pkg::MODE_IDLE;
            term       = 8'd0;
            acc        = 8'd0;
            oct_cnt    = 2'd0;
            errors     = 0;
            live_items = 0;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function void push_char(logic [7:0] c);
            qsed_pkg::out_item_t r;
            r.has_byte    = 1'b1;
            r.out_byte    = c;
            r.string_done = 1'b0;
            expected_chars = {expected_chars, r};
        endfunction

        function void push_done();
            qsed_pkg::out_item_t r;
            r.has_byte    = 1'b0;
            r.out_byte    = 8'd0;
            r.string_done = 1'b1;
            expected_chars = {expected_chars, r};
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= qsed_pkg::CH_ZERO && c <= qsed_pkg::CH_NINE)
                return int'(c - qsed_pkg::CH_ZERO);
            if (c >= qsed_pkg::CH_A_LOWER && c <= qsed_pkg::CH_F_LOWER)
                return int'(c - qsed_pkg::CH_A_LOWER) + 10;
            if (c >= qsed_pkg::CH_A_UPPER && c <= qsed_pkg::CH_F_UPPER)
                return int'(c - qsed_pkg::CH_A_UPPER) + 10;
            return -1;
        endfunction

        function bit is_octal(logic [7:0] c);
            return (c >= qsed_pkg::CH_ZERO && c <= qsed_pkg::CH_SEVEN);
        endfunction

        function void take_plain(logic [7:0] c);
            if (c == term) begin
                mode = qsed_pkg::MODE_IDLE;
                push_done();
            end else if (c == qsed_pkg::CH_BACKSLASH) begin
                mode = qsed_pkg::MODE_ESCAPE;
            end else begin
                mode = qsed_pkg::MODE_PLAIN;
                push_char(c);
            end
        endfunction

        function void take_escape(logic [7:0] c);
            mode = qsed_pkg::MODE_PLAIN;
            case (c)
                qsed_pkg::CH_B:       push_char(qsed_pkg::CODE_BS);
                qsed_pkg::CH_F:       push_char(qsed_pkg::CODE_FF);
                qsed_pkg::CH_N:       push_char(qsed_pkg::CODE_LF);
                qsed_pkg::CH_R:       push_char(qsed_pkg::CODE_CR);
                qsed_pkg::CH_T:       push_char(qsed_pkg::CODE_TAB);
                qsed_pkg::CH_X_LOWER,
                qsed_pkg::CH_X_UPPER:
                begin
                    mode = qsed_pkg::MODE_HEX;
                    acc  = 8'd0;
                end
                default:
                begin
                    if (is_octal(c)) begin
                        mode    = qsed_pkg::MODE_OCTAL;
                        acc     = c - qsed_pkg::CH_ZERO;
                        oct_cnt = 2'd1;
                    end else begin
                        push_char(c);
                    end
                end
            endcase
        endfunction

        // Work out the results that one accepted input transfer causes
        function void note_input(qsed_pkg::in_item_t it);
            int         d;
            logic [7:0] c;
            c = it.data_byte;
            if (mode == qsed_pkg::MODE_IDLE && (it.stream_end || !it.is_open_quote))
                return;
            live_items++;
            if (it.stream_end) begin
                if (mode == qsed_pkg::MODE_HEX || mode == qsed_pkg::MODE_OCTAL)
                    push_char(acc);
                mode    = qsed_pkg::MODE_IDLE;
                oct_cnt = 2'd0;
                push_done();
                return;
            end
            if (it.is_open_quote) begin
                term    = c;
                mode    = qsed_pkg::MODE_PLAIN;
                acc     = 8'd0;
                oct_cnt = 2'd0;
                return;
            end
            case (mode)
                qsed_pkg::MODE_PLAIN:  take_plain(c);
                qsed_pkg::MODE_ESCAPE: take_escape(c);
                qsed_pkg::MODE_HEX:
                begin
                    d = hex_value(c);
                    if (d >= 0) begin
                        acc = {acc[3:0], 4'(d)};
                    end else begin
                        push_char(acc);
                        take_plain(c);
                    end
                end
                qsed_pkg::MODE_OCTAL:
                begin
                    if (is_octal(c)) begin
                        acc     = (acc << 3) + (c - qsed_pkg::CH_ZERO);
                        oct_cnt = oct_cnt + 2'd1;
                        if (oct_cnt == qsed_pkg::OCT_LAST) begin
                            mode    = qsed_pkg::MODE_PLAIN;
                            oct_cnt = 2'd0;
                            push_char(acc);
                        end
                    end else begin
                        oct_cnt = 2'd0;
                        push_char(acc);
                        take_plain(c);
                    end
                end
                default: mode = qsed_pkg::MODE_IDLE;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("MISMATCH: %s", msg);
        endtask

        task check_result(qsed_pkg::out_item_t got);
            qsed_pkg::out_item_t want;
            if (expected_chars.size() == 0) begin
                report($sformatf("unexpected result has=%0b byte=%02h done=%0b",
                                 got.has_byte, got.out_byte, got.string_done));
                return;
            end
            want = expected_chars.pop_front();
            if (got.has_byte !== want.has_byte)
                report($sformatf("has_byte got %0b want %0b", got.has_byte, want.has_byte));
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
            if (got.string_done !== want.string_done)
                report($sformatf("string_done got %0b want %0b",
                                 got.string_done, want.string_done));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    qsed_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_ready;
    qsed_pkg::out_item_t out_item;

    int gap_pct;
    int stall_pct;
    int cycles;

    escape_scoreboard sb;

    quoted_string_escape_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_input(in_item);
            if (out_valid && out_ready)
                sb.check_result(out_item);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Hold the payload until the transfer completes
    task send_item(input logic [7:0] b, input logic open, input logic fin);
        qsed_pkg::in_item_t it;
        it.data_byte     = b;
        it.is_open_quote = open;
        it.stream_end    = fin;
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task send_char(input logic [7:0] b);
        send_item(b, 1'b0, 1'b0);
    endtask

    task open_string(input logic [7:0] b);
        send_item(b, 1'b1, 1'b0);
    endtask

    task end_stream();
        send_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    endtask

    function logic [7:0] random_hex_char();
        int v;
        v = $urandom_range(21);
        if (v < 10)
            return qsed_pkg::CH_ZERO + 8'(v);
        if (v < 16)
            return qsed_pkg::CH_A_LOWER + 8'(v - 10);
        return qsed_pkg::CH_A_UPPER + 8'(v - 16);
    endfunction

    function logic [7:0] random_escape_code();
        case ($urandom_range(4))
            0:       return qsed_pkg::CH_B;
            1:       return qsed_pkg::CH_F;
            2:       return qsed_pkg::CH_N;
            3:       return qsed_pkg::CH_R;
            default: return qsed_pkg::CH_T;
        endcase
    endfunction

    task send_random_string();
        logic [7:0] term;
        logic [7:0] c;
        int         segs;
        int         n;
        int         pick;
        // Occasional noise transfer, flags included
        if ($urandom_range(99) < 8) begin
            send_item(8'($urandom_range(255)), $urandom_range(3) == 0,
                      $urandom_range(5) == 0);
            return;
        end
        if ($urandom_range(9) == 0)
            send_char(8'($urandom_range(255)));
        pick = $urandom_range(9);
        if (pick < 5)
            term = CH_DQUOTE;
        else if (pick < 7)
            term = CH_SQUOTE;
        else if (pick == 7)
            term = random_hex_char();
        else
            term = 8'($urandom_range(255));
        open_string(term);
        segs = $urandom_range(10);
        for (int s = 0; s < segs; s++) begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    c = 8'($urandom_range(255));
                    if (c == term)
                        c = 8'($urandom_range(255));
                    send_char(c);
                end
                4:
                begin
                    send_char(qsed_pkg::CH_BACKSLASH);
                    send_char(random_escape_code());
                end
                5:
                begin
                    send_char(qsed_pkg::CH_BACKSLASH);
                    send_char(8'($urandom_range(255)));
                end
                6:
                begin
                    send_char(qsed_pkg::CH_BACKSLASH);
                    send_char($urandom_range(1) ? qsed_pkg::CH_X_LOWER
                                                : qsed_pkg::CH_X_UPPER);
                    n = $urandom_range(4);
                    for (int k = 0; k < n; k++)
                        send_char(random_hex_char());
                end
                7:
                begin
                    send_char(qsed_pkg::CH_BACKSLASH);
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++)
                        send_char(qsed_pkg::CH_ZERO + 8'($urandom_range(7)));
                end
                8:
                begin
                    send_char(qsed_pkg::CH_BACKSLASH);
                    send_char($urandom_range(1) ? term : qsed_pkg::CH_BACKSLASH);
                end
                default: send_char(8'($urandom_range(8'h20, 8'h7E)));
            endcase
        end
        pick = $urandom_range(9);
        if (pick < 7) begin
            send_char(term);
        end else if (pick < 9) begin
            if ($urandom_range(3) == 0)
                send_char(qsed_pkg::CH_BACKSLASH);
            end_stream();
        end
        // otherwise leave it open; the next opening quote abandons it
    endtask

    initial
    begin
        sb        = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        cycles    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle bytes and idle stream end are dropped
        send_char(8'h7A);
        end_stream();
        open_string(CH_DQUOTE);
        send_char(8'hFF);
        send_char(qsed_pkg::CH_BACKSLASH);
        send_char(qsed_pkg::CH_N);
        // hex value keeps low 8 bits, flushed by the terminator
        send_char(qsed_pkg::CH_BACKSLASH);
        send_char(qsed_pkg::CH_X_LOWER);
        send_char(qsed_pkg::CH_ZERO + 8'd1);
        send_char(qsed_pkg::CH_ZERO + 8'd2);
        send_char(qsed_pkg::CH_ZERO + 8'd3);
        send_char(CH_DQUOTE);
        // pending hex abandoned by a fresh opening quote
        open_string(CH_SQUOTE);
        send_char(qsed_pkg::CH_BACKSLASH);
        send_char(qsed_pkg::CH_X_UPPER);
        send_char(qsed_pkg::CH_A_UPPER);
        open_string(qsed_pkg::CH_ZERO + 8'd1);
        // octal digits equal to the terminator still count as digits
        send_char(qsed_pkg::CH_BACKSLASH);
        send_char(qsed_pkg::CH_ZERO + 8'd1);
        send_char(qsed_pkg::CH_ZERO);
        send_char(qsed_pkg::CH_ZERO + 8'd1);
        send_char(qsed_pkg::CH_BACKSLASH);
        send_char(qsed_pkg::CH_SEVEN);
        send_char(8'h71);
        send_char(qsed_pkg::CH_BACKSLASH);
        send_char(qsed_pkg::CH_BACKSLASH);
        // escaped terminator starts an octal value; backslash dropped at end
        send_char(qsed_pkg::CH_BACKSLASH);
        send_char(qsed_pkg::CH_ZERO + 8'd1);
        send_char(qsed_pkg::CH_BACKSLASH);
        end_stream();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 63; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 63; end
                default: begin gap_pct = 38; stall_pct = 38; end
            endcase
            while (sb.live_items < (phase + 1) * ITEM_TARGET / 4)
                send_random_string();
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
